/* rtl/servo_command_packet_framer_core_assert.svh */
// Assertion macros shared by the servo packet framer checkers.
// Needs only a clock and an active-low reset in the including scope.
`ifndef SERVO_COMMAND_PACKET_FRAMER_CORE_ASSERT_SVH
`define SERVO_COMMAND_PACKET_FRAMER_CORE_ASSERT_SVH

// Checked only while out of reset.
`define SCPF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every edge, reset cycles included.
`define SCPF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/scpf_pkg.sv */
// Types, constants and encoding helpers for the servo command packet framer.
// No dependencies.
package scpf_pkg;

    localparam int unsigned InWidth     = 80;
    localparam int unsigned DataBytes   = 5;
    localparam int unsigned PktBytes    = 12;
    localparam int unsigned HdrBytes    = 7;

    typedef enum logic [2:0] {
        ACT_STATUS   = 3'd0,
        ACT_LED      = 3'd1,
        ACT_TORQUE   = 3'd2,
        ACT_POS_READ = 3'd3,
        ACT_MOVE_POS = 3'd4,
        ACT_MOVE_SPD = 3'd5
    } action_t;

    localparam logic [7:0] HdrByte      = 8'hFF;
    localparam logic [7:0] CheckMask    = 8'hFE;
    localparam logic [7:0] CmdStatus    = 8'h07;
    localparam logic [7:0] CmdRamWrite  = 8'h03;
    localparam logic [7:0] CmdRamRead   = 8'h04;
    localparam logic [7:0] CmdMove      = 8'h06;
    localparam logic [7:0] AddrLed      = 8'h35;
    localparam logic [7:0] AddrTorque   = 8'h34;
    localparam logic [7:0] AddrPosition = 8'h3A;
    localparam logic [7:0] LenOne       = 8'h01;
    localparam logic [7:0] LenTwo       = 8'h02;
    localparam logic [7:0] PosCtrl      = 8'h04;
    localparam logic [7:0] SpdCtrl      = 8'h06;
    localparam logic [7:0] SpdPlayTime  = 8'd45;

    localparam logic [9:0]  PosMax      = 10'd1023;
    localparam logic [15:0] SpdDirBit   = 16'h4000;

    // Play time is (ms*10 + 56) / 112. The divide by 112 is a shift by four
    // and then a divide by 7 done as a multiply by a rounded-up reciprocal.
    localparam int unsigned PlayRound   = 56;
    localparam int unsigned PlayDiv     = 112;
    localparam int unsigned PlaySat     = 256 * PlayDiv;
    localparam int unsigned RecipShift  = 14;
    localparam int unsigned Recip7      = ((1 << RecipShift) + 6) / 7;

    typedef struct packed {
        logic [7:0]                  sid;
        logic [7:0]                  cmd;
        logic [2:0]                  ndata;
        logic [DataBytes-1:0][7:0]   data;
    } req_t;

    function automatic logic [7:0] play_time(input logic [15:0] dur);
        logic [19:0] x;
        logic [10:0] y;
        logic [22:0] prod;
        logic [7:0]  q;
        x    = ({4'b0, dur} << 3) + ({4'b0, dur} << 1) + 20'(PlayRound);
        y    = x[14:4];
        prod = {12'b0, y} * 23'(Recip7);
        q    = prod[RecipShift +: 8];
        if (x >= 20'(PlaySat)) begin
            q = 8'hFF;
        end
        return q;
    endfunction

    function automatic logic [15:0] speed_word(input logic [15:0] spd);
        logic [15:0] w;
        w = spd;
        if (spd[15]) begin
            w = (16'd0 - spd) | SpdDirBit;
        end
        return w;
    endfunction

    function automatic logic [9:0] pos_sat(input logic [15:0] pos);
        logic [9:0] p;
        p = pos[9:0];
        if (pos > {6'b0, PosMax}) begin
            p = PosMax;
        end
        return p;
    endfunction

endpackage

/* rtl/servo_command_packet_framer_core.sv */
// A taken request is registered in the request stage and then loaded into the packet
// shift register, from which the first packet word is presented.
// Throughput: one packet word per cycle while m_tready is high. Packets are 7, 9,
// 10 or 12 words long; a next request is taken while the current packet shifts out.
// Requests with action codes 6 and 7 are consumed and produce no words.
// Reset (aresetn low, synchronous) empties the request and packet stages.
// Depends on scpf_pkg.
module servo_command_packet_framer_core
    import scpf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    // action[2:0], servo_id[10:3], led_color[18:11], torque_mode[26:19],
    // target_position[42:27], duration_ms[58:43], speed[74:59], zero pad
    input  logic [InWidth-1:0] s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    // packet_byte[7:0]
    output logic [7:0]         m_tdata,
    // last_byte
    output logic               m_tlast
);

    action_t     in_action;
    logic [7:0]  in_sid;
    logic [7:0]  in_led;
    logic [7:0]  in_torque;
    logic [15:0] in_pos;
    logic [15:0] in_dur;
    logic [15:0] in_spd;
    logic [9:0]  pos_w;
    logic [15:0] spd_w;

    req_t        req_next;
    req_t        req_reg;
    logic        req_keep;
    logic        in_valid_reg;
    logic        in_valid_next;

    logic [PktBytes-1:0][7:0] pkt_reg;
    logic [PktBytes-1:0][7:0] pkt_next;
    logic [PktBytes-1:0][7:0] pkt_build;
    logic [3:0]  cnt_reg;
    logic [3:0]  cnt_next;
    logic [3:0]  size;
    logic [7:0]  chk;
    logic [7:0]  chk1;
    logic        in_fire;
    logic        out_fire;
    logic        load;

    assign in_action = action_t'(s_tdata[2:0]);
    assign in_sid    = s_tdata[10:3];
    assign in_led    = s_tdata[18:11];
    assign in_torque = s_tdata[26:19];
    assign in_pos    = s_tdata[42:27];
    assign in_dur    = s_tdata[58:43];
    assign in_spd    = s_tdata[74:59];
    assign pos_w     = pos_sat(in_pos);
    assign spd_w     = speed_word(in_spd);

    // Request decode: data bytes beyond ndata stay zero so the checksum
    // can fold all five slots.
    always_comb begin
        req_next       = '0;
        req_next.sid   = in_sid;
        req_keep       = 1'b1;
        unique case (in_action)
            ACT_STATUS: begin
                req_next.cmd = CmdStatus;
            end
            ACT_LED: begin
                req_next.cmd     = CmdRamWrite;
                req_next.ndata   = 3'd3;
                req_next.data[0] = AddrLed;
                req_next.data[1] = LenOne;
                req_next.data[2] = in_led;
            end
            ACT_TORQUE: begin
                req_next.cmd     = CmdRamWrite;
                req_next.ndata   = 3'd3;
                req_next.data[0] = AddrTorque;
                req_next.data[1] = LenOne;
                req_next.data[2] = in_torque;
            end
            ACT_POS_READ: begin
                req_next.cmd     = CmdRamRead;
                req_next.ndata   = 3'd2;
                req_next.data[0] = AddrPosition;
                req_next.data[1] = LenTwo;
            end
            ACT_MOVE_POS: begin
                req_next.cmd     = CmdMove;
                req_next.ndata   = 3'd5;
                req_next.data[0] = play_time(in_dur);
                req_next.data[1] = pos_w[7:0];
                req_next.data[2] = {6'b0, pos_w[9:8]};
                req_next.data[3] = PosCtrl;
                req_next.data[4] = in_sid;
            end
            ACT_MOVE_SPD: begin
                req_next.cmd     = CmdMove;
                req_next.ndata   = 3'd5;
                req_next.data[0] = SpdPlayTime;
                req_next.data[1] = spd_w[7:0];
                req_next.data[2] = spd_w[15:8];
                req_next.data[3] = SpdCtrl;
                req_next.data[4] = in_sid;
            end
            default: begin
                req_keep = 1'b0;
            end
        endcase
    end

    // Packet assembly from the registered request.
    always_comb begin
        size = 4'(HdrBytes) + {1'b0, req_reg.ndata};
        chk  = {4'b0, size} ^ req_reg.sid ^ req_reg.cmd;
        for (int i = 0; i < DataBytes; i++) begin
            chk = chk ^ req_reg.data[i];
        end
        chk1 = chk & CheckMask;
        pkt_build[0] = HdrByte;
        pkt_build[1] = HdrByte;
        pkt_build[2] = {4'b0, size};
        pkt_build[3] = req_reg.sid;
        pkt_build[4] = req_reg.cmd;
        pkt_build[5] = chk1;
        pkt_build[6] = (~chk1) & CheckMask;
        for (int i = 0; i < DataBytes; i++) begin
            pkt_build[HdrBytes + i] = req_reg.data[i];
        end
    end

    assign m_tvalid = (cnt_reg != 4'd0);
    assign m_tdata  = pkt_reg[0];
    assign m_tlast  = (cnt_reg == 4'd1);
    assign out_fire = m_tvalid && m_tready;
    // The next packet loads on the same edge that the last word leaves.
    assign load     = in_valid_reg && ((cnt_reg == 4'd0) || (out_fire && m_tlast));
    assign s_tready = !in_valid_reg || load;
    assign in_fire  = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_fire) begin
            in_valid_next = req_keep;
        end else if (load) begin
            in_valid_next = 1'b0;
        end
        pkt_next = pkt_reg;
        cnt_next = cnt_reg;
        if (load) begin
            pkt_next = pkt_build;
            cnt_next = size;
        end else if (out_fire) begin
            pkt_next = {8'h00, pkt_reg[PktBytes-1:1]};
            cnt_next = cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            cnt_reg      <= 4'd0;
        end else begin
            in_valid_reg <= in_valid_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            req_reg <= req_next;
        end
        pkt_reg <= pkt_next;
    end

endmodule

/* rtl/scpf_checker.sv */
// Port-level checks for the servo command packet framer, bound to the top level.
// Depends on scpf_pkg and servo_command_packet_framer_core_assert.svh.
`include "servo_command_packet_framer_core_assert.svh"

module scpf_checker
    import scpf_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    // packet_byte[7:0]
    input logic [7:0]         m_tdata,
    input logic               m_tlast
);

    logic [3:0] pos_reg;
    logic [3:0] pos_next;

    // Position of the current word inside its packet.
    always_comb begin
        pos_next = pos_reg;
        if (m_tvalid && m_tready) begin
            pos_next = m_tlast ? 4'd0 : pos_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 4'd0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    `SCPF_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled word changed")
    `SCPF_ASSERT(a_hdr, aclk, aresetn, m_tvalid && (pos_reg == 4'd0 || pos_reg == 4'd1) |-> m_tdata == HdrByte, "packet header word is not 0xFF")
    `SCPF_ASSERT(a_len, aclk, aresetn, m_tvalid && m_tlast |-> pos_reg == 4'd6 || pos_reg == 4'd8 || pos_reg == 4'd9 || pos_reg == 4'd11, "packet length is not 7 9 10 or 12")
    `SCPF_ASSERT_ALWAYS(a_rst_idle, aclk, !aresetn |=> !m_tvalid && s_tready, "framer not empty after reset")

endmodule

bind servo_command_packet_framer_core scpf_checker u_scpf_checker (.*);
